// ===== src/pac_pkg.sv =====
// Package for the prefix accumulator core: codes, state types and the result record.
// Has no dependencies. pac_mem, pac_core, the top level and the testbench import it.
package pac_pkg;

  localparam int unsigned PAC_MEM_AW_DEF = 16;

  localparam logic [31:0] NFIX_FILL    = 32'hFFFF_FF00;
  localparam logic [31:0] OPR_BRB      = 32'd0;
  localparam logic [31:0] OPR_ADD      = 32'd1;
  localparam logic [31:0] OPR_SUB      = 32'd2;
  localparam logic [31:0] OPR_SVC      = 32'd3;
  localparam logic [31:0] SVC_EXIT     = 32'd0;
  localparam logic [31:0] SVC_LAST_IO  = 32'd2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } pac_func_e;

  typedef enum logic [3:0] {
    OP_LDAM = 4'd0,
    OP_LDBM = 4'd1,
    OP_STAM = 4'd2,
    OP_LDAC = 4'd3,
    OP_LDBC = 4'd4,
    OP_LDAP = 4'd5,
    OP_LDAI = 4'd6,
    OP_LDBI = 4'd7,
    OP_STAI = 4'd8,
    OP_BR   = 4'd9,
    OP_BRZ  = 4'd10,
    OP_BRN  = 4'd11,
    OP_OPR  = 4'd13,
    OP_PFIX = 4'd14,
    OP_NFIX = 4'd15
  } pac_op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SVC     = 3'd1,
    ST_EXIT    = 3'd2,
    ST_INVALID = 3'd3,
    ST_HALTED  = 3'd4
  } pac_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_DONE
  } pac_state_e;

  typedef enum logic [1:0] {
    DST_A,
    DST_B,
    DST_HOST
  } pac_dst_e;

  typedef struct packed {
    logic [31:0] pc_value;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic [31:0] read_word;
    pac_status_e status;
    logic [31:0] svc_code;
  } pac_res_t;

endpackage

// ===== src/pac_req_if.sv =====
// Request channel of the prefix accumulator core: valid, ready and the request fields.
// Depends on nothing.
interface pac_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] word_addr;
  logic [31:0] write_word;

  modport source (output valid, output func, output word_addr, output write_word,
                  input ready);
  modport sink   (input valid, input func, input word_addr, input write_word,
                  output ready);
endinterface

// ===== src/pac_rsp_if.sv =====
// Result channel of the prefix accumulator core: valid, ready and the result fields.
// Depends on nothing.
interface pac_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc_value;
  logic [31:0] a_value;
  logic [31:0] b_value;
  logic [31:0] read_word;
  logic [2:0]  status;
  logic [31:0] svc_code;

  modport source (output valid, output pc_value, output a_value, output b_value,
                  output read_word, output status, output svc_code, input ready);
  modport sink   (input valid, input pc_value, input a_value, input b_value,
                  input read_word, input status, input svc_code, output ready);
endinterface

// ===== src/pac_mem.sv =====
// Word memory of the prefix accumulator core: one port, registered read data.
// Depends on pac_pkg for the default address width; the top level sets the actual width.
module pac_mem
  import pac_pkg::*;
#(
  parameter int unsigned MEM_AW = PAC_MEM_AW_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [31:0]       wdata_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [2**MEM_AW];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pac_core.sv =====
// Sequencer and register set of the prefix accumulator core: fetch, decode, execute.
// Depends on pac_pkg and pac_req_if; drives the port of pac_mem.
module pac_core
  import pac_pkg::*;
#(
  parameter int unsigned MEM_AW = PAC_MEM_AW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pac_req_if.sink           req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pac_res_t          res_o,
  output logic              mem_we_o,
  output logic [MEM_AW-1:0] mem_addr_o,
  output logic [31:0]       mem_wdata_o,
  input  logic [31:0]       mem_rdata_i
);

  pac_state_e  state_q, state_d;
  logic [31:0] pc_q, pc_d;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] opnd_q, opnd_d;
  logic        run_q, run_d;
  pac_status_e st_q, st_d;
  logic [31:0] rd_q, rd_d;
  logic [31:0] svc_q, svc_d;
  pac_dst_e    dst_q, dst_d;

  logic        accept;
  logic [31:0] host_addr;
  logic [7:0]  fbyte;
  logic [31:0] opnd_new;
  logic [31:0] pc_inc;
  logic [31:0] pc_rel;
  logic [31:0] a_idx;
  logic [31:0] b_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign host_addr   = {16'd0, req_i.word_addr};

  always_comb begin
    unique case (pc_q[1:0])
      2'd0: fbyte = mem_rdata_i[7:0];
      2'd1: fbyte = mem_rdata_i[15:8];
      2'd2: fbyte = mem_rdata_i[23:16];
      2'd3: fbyte = mem_rdata_i[31:24];
    endcase
  end

  assign opnd_new = opnd_q | {28'd0, fbyte[3:0]};
  assign pc_inc   = pc_q + 32'd1;
  assign pc_rel   = pc_inc + opnd_new;
  assign a_idx    = a_q + opnd_new;
  assign b_idx    = b_q + opnd_new;

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    a_d         = a_q;
    b_d         = b_q;
    opnd_d      = opnd_q;
    run_d       = run_q;
    st_d        = st_q;
    rd_d        = rd_q;
    svc_d       = svc_q;
    dst_d       = dst_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = pc_q[MEM_AW+1:2];
    mem_wdata_o = a_q;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          rd_d    = '0;
          svc_d   = '0;
          dst_d   = DST_HOST;
          state_d = S_DONE;
          unique case (pac_func_e'(req_i.func))
            FUNC_WRITE: begin
              mem_we_o    = 1'b1;
              mem_addr_o  = host_addr[MEM_AW-1:0];
              mem_wdata_o = req_i.write_word;
            end
            FUNC_READ: begin
              mem_addr_o = host_addr[MEM_AW-1:0];
              state_d    = S_LOAD;
            end
            FUNC_EXEC: begin
              if (run_q) begin
                state_d = S_FETCH;
              end else begin
                st_d = ST_HALTED;
              end
            end
            FUNC_NONE: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FETCH: begin
        pc_d    = pc_inc;
        opnd_d  = '0;
        state_d = S_DONE;
        unique case (pac_op_e'(fbyte[7:4]))
          OP_LDAM: begin
            mem_addr_o = opnd_new[MEM_AW-1:0];
            dst_d      = DST_A;
            state_d    = S_LOAD;
          end
          OP_LDBM: begin
            mem_addr_o = opnd_new[MEM_AW-1:0];
            dst_d      = DST_B;
            state_d    = S_LOAD;
          end
          OP_STAM: begin
            mem_we_o   = 1'b1;
            mem_addr_o = opnd_new[MEM_AW-1:0];
          end
          OP_LDAC: a_d = opnd_new;
          OP_LDBC: b_d = opnd_new;
          OP_LDAP: a_d = pc_rel;
          OP_LDAI: begin
            mem_addr_o = a_idx[MEM_AW-1:0];
            dst_d      = DST_A;
            state_d    = S_LOAD;
          end
          OP_LDBI: begin
            mem_addr_o = b_idx[MEM_AW-1:0];
            dst_d      = DST_B;
            state_d    = S_LOAD;
          end
          OP_STAI: begin
            mem_we_o   = 1'b1;
            mem_addr_o = b_idx[MEM_AW-1:0];
          end
          OP_BR: pc_d = pc_rel;
          OP_BRZ: begin
            if (a_q == '0) begin
              pc_d = pc_rel;
            end
          end
          OP_BRN: begin
            if (a_q[31]) begin
              pc_d = pc_rel;
            end
          end
          OP_OPR: begin
            unique case (opnd_new)
              OPR_BRB: pc_d = b_q;
              OPR_ADD: a_d = a_q + b_q;
              OPR_SUB: a_d = a_q - b_q;
              OPR_SVC: begin
                svc_d = a_q;
                priority if (a_q == SVC_EXIT) begin
                  run_d = 1'b0;
                  st_d  = ST_EXIT;
                end else if (a_q <= SVC_LAST_IO) begin
                  st_d = ST_SVC;
                end else begin
                  run_d = 1'b0;
                  st_d  = ST_INVALID;
                end
              end
              default: begin
                run_d = 1'b0;
                st_d  = ST_INVALID;
              end
            endcase
          end
          OP_PFIX: opnd_d = opnd_new << 4;
          OP_NFIX: opnd_d = NFIX_FILL | (opnd_new << 4);
          default: begin
            run_d = 1'b0;
            st_d  = ST_INVALID;
          end
        endcase
      end

      S_LOAD: begin
        state_d = S_DONE;
        unique case (dst_q)
          DST_A:    a_d  = mem_rdata_i;
          DST_B:    b_d  = mem_rdata_i;
          DST_HOST: rd_d = mem_rdata_i;
          default:  rd_d = mem_rdata_i;
        endcase
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.pc_value  = pc_q;
  assign res_o.a_value   = a_q;
  assign res_o.b_value   = b_q;
  assign res_o.read_word = rd_q;
  assign res_o.status    = st_q;
  assign res_o.svc_code  = svc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      opnd_q  <= '0;
      run_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      a_q     <= a_d;
      b_q     <= b_d;
      opnd_q  <= opnd_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    rd_q  <= rd_d;
    svc_q <= svc_d;
    dst_q <= dst_d;
  end

endmodule

// ===== src/prefix_accumulator_cpu_core.sv =====
// Top level of the prefix accumulator core: sequencer, word memory, result register.
// Depends on pac_pkg, pac_req_if, pac_rsp_if, pac_mem and pac_core.
//
//   Channel  Dir  Handshake     Fields
//   req_i    in   valid/ready   func, word_addr, write_word
//   rsp_o    out  valid/ready   pc_value, a_value, b_value, read_word, status, svc_code
//
// One request is in work at a time. A memory write, halted step or unused function goes
// straight to the result state, a memory read or plain instruction first passes the load
// or fetch state, and an instruction that loads a word passes fetch and then load.
// Results pass through an output register, so a new request is taken while one waits.
// Reset clears the sequencer, pc, a, b, operand and output valid at once; not the memory.
module prefix_accumulator_cpu_core
  import pac_pkg::*;
#(
  parameter int unsigned MEM_AW = PAC_MEM_AW_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  pac_req_if.sink   req_i,
  pac_rsp_if.source rsp_o
);

  logic              res_valid;
  logic              res_ready;
  pac_res_t          res;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [31:0]       mem_wdata;
  logic [31:0]       mem_rdata;
  logic              out_valid_q, out_valid_d;
  pac_res_t          out_q;

  pac_core #(
    .MEM_AW (MEM_AW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  pac_mem #(
    .MEM_AW (MEM_AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.pc_value  = out_q.pc_value;
  assign rsp_o.a_value   = out_q.a_value;
  assign rsp_o.b_value   = out_q.b_value;
  assign rsp_o.read_word = out_q.read_word;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.svc_code  = out_q.svc_code;

endmodule

// ===== tb/prefix_accumulator_cpu_core_tb.sv =====
// Testbench for the prefix accumulator core: host memory access, every instruction, syscalls,
// random programs under several idle and stall mixes, a long result hold and a final halt.
// Depends on pac_pkg, pac_req_if, pac_rsp_if and prefix_accumulator_cpu_core.
module prefix_accumulator_cpu_core_tb
  import pac_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS   = 1 << PAC_MEM_AW_DEF;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam logic [3:0]  OP_UNUSED   = 4'd12;
  localparam logic [3:0]  OPR_UNDEF   = 4'd7;
  localparam logic [3:0]  SVC_UNKNOWN = 4'd9;

  logic clk_i;
  logic rst_ni;

  pac_req_if req_bus ();
  pac_rsp_if rsp_bus ();

  prefix_accumulator_cpu_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  logic [31:0] mem_img [int unsigned];
  logic [15:0] written_addrs [$];
  logic [31:0] cpu_pc;
  logic [31:0] cpu_a;
  logic [31:0] cpu_b;
  logic [31:0] cpu_oreg;
  bit          cpu_running;

  pac_res_t    expected_steps [$];
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned useful_sent     = 0;
  int unsigned idle_pct        = 0;
  int unsigned stall_pct       = 0;
  int unsigned hold_reqs       = 0;
  int unsigned holds_seen      = 0;
  int unsigned hold_left       = 0;
  int unsigned cycles          = 0;
  string       halt_cause      = "none";

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  function automatic int unsigned word_idx(logic [31:0] a);
    return a & (MEM_WORDS - 1);
  endfunction

  function automatic logic [31:0] load_word(logic [31:0] a);
    int unsigned i;
    i = word_idx(a);
    if (!mem_img.exists(i)) begin
      mismatches++;
      $display("%0t: stimulus read word %h before writing it", $time, i);
      return '0;
    end
    return mem_img[i];
  endfunction

  function automatic void store_word(logic [31:0] a, logic [31:0] v);
    int unsigned i;
    i = word_idx(a);
    if (!mem_img.exists(i)) written_addrs.push_back(16'(i));
    mem_img[i] = v;
  endfunction

  function automatic void halt_core(output pac_status_e st, input pac_status_e code);
    cpu_running = 1'b0;
    st = code;
  endfunction

  function automatic void execute_instr(output pac_status_e st, output logic [31:0] svc);
    logic [31:0] w;
    logic [7:0]  ins;
    logic [3:0]  op;
    bit          keep_oreg;
    st = ST_OK;
    svc = '0;
    keep_oreg = 1'b0;
    w = load_word(cpu_pc >> 2);
    ins = w[8*cpu_pc[1:0] +: 8];
    op = ins[7:4];
    cpu_pc = cpu_pc + 32'd1;
    cpu_oreg = cpu_oreg | ins[3:0];
    case (op)
      OP_LDAM: cpu_a = load_word(cpu_oreg);
      OP_LDBM: cpu_b = load_word(cpu_oreg);
      OP_STAM: store_word(cpu_oreg, cpu_a);
      OP_LDAC: cpu_a = cpu_oreg;
      OP_LDBC: cpu_b = cpu_oreg;
      OP_LDAP: cpu_a = cpu_pc + cpu_oreg;
      OP_LDAI: cpu_a = load_word(cpu_a + cpu_oreg);
      OP_LDBI: cpu_b = load_word(cpu_b + cpu_oreg);
      OP_STAI: store_word(cpu_b + cpu_oreg, cpu_a);
      OP_BR:   cpu_pc = cpu_pc + cpu_oreg;
      OP_BRZ:  if (cpu_a == '0) cpu_pc = cpu_pc + cpu_oreg;
      OP_BRN:  if (cpu_a[31]) cpu_pc = cpu_pc + cpu_oreg;
      OP_OPR: begin
        case (cpu_oreg)
          OPR_BRB: cpu_pc = cpu_b;
          OPR_ADD: cpu_a = cpu_a + cpu_b;
          OPR_SUB: cpu_a = cpu_a - cpu_b;
          OPR_SVC: begin
            svc = cpu_a;
            if (cpu_a == SVC_EXIT) halt_core(st, ST_EXIT);
            else if (cpu_a <= SVC_LAST_IO) st = ST_SVC;
            else halt_core(st, ST_INVALID);
          end
          default: halt_core(st, ST_INVALID);
        endcase
      end
      OP_PFIX: begin
        cpu_oreg = cpu_oreg << 4;
        keep_oreg = 1'b1;
      end
      OP_NFIX: begin
        cpu_oreg = NFIX_FILL | (cpu_oreg << 4);
        keep_oreg = 1'b1;
      end
      default: halt_core(st, ST_INVALID);
    endcase
    if (!keep_oreg) cpu_oreg = '0;
  endfunction

  function automatic pac_res_t predict_step(pac_func_e fn, logic [15:0] addr,
                                            logic [31:0] wdata);
    pac_res_t r;
    r = '0;
    case (fn)
      FUNC_WRITE: store_word(addr, wdata);
      FUNC_READ:  r.read_word = load_word(addr);
      FUNC_EXEC: begin
        if (cpu_running) execute_instr(r.status, r.svc_code);
        else r.status = ST_HALTED;
      end
      default: ;
    endcase
    r.pc_value = cpu_pc;
    r.a_value  = cpu_a;
    r.b_value  = cpu_b;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic void compare_result();
    pac_res_t exp_r;
    if (expected_steps.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, expected none, got pc %h status %0d",
               $time, rsp_bus.pc_value, rsp_bus.status);
      return;
    end
    exp_r = expected_steps.pop_front();
    check_field("pc_value", exp_r.pc_value, rsp_bus.pc_value);
    check_field("a_value", exp_r.a_value, rsp_bus.a_value);
    check_field("b_value", exp_r.b_value, rsp_bus.b_value);
    check_field("read_word", exp_r.read_word, rsp_bus.read_word);
    check_field("status", 32'(exp_r.status), 32'(rsp_bus.status));
    check_field("svc_code", exp_r.svc_code, rsp_bus.svc_code);
    results_checked++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) compare_result();
    if (hold_reqs != holds_seen) begin
      holds_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("prefix_accumulator_cpu_core_tb: done, errors");
      $finish;
    end
  end

  task automatic send_req(input pac_func_e fn, input logic [15:0] addr,
                          input logic [31:0] wdata);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.func       <= fn;
    req_bus.word_addr  <= addr;
    req_bus.write_word <= wdata;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    if (fn == FUNC_WRITE || fn == FUNC_READ || (fn == FUNC_EXEC && cpu_running))
      useful_sent++;
    expected_steps.push_back(predict_step(fn, addr, wdata));
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_steps.size() != 0);
  endtask

  // Places the instruction byte at the program counter, backs any word that it loads, and executes it.
  task automatic run_op(input logic [7:0] ins);
    int unsigned fetch_idx;
    int unsigned lane;
    logic [31:0] w;
    logic [31:0] oper;
    logic [31:0] data_addr;
    bit          is_load;
    fetch_idx = word_idx(cpu_pc >> 2);
    lane = cpu_pc[1:0];
    w = mem_img.exists(fetch_idx) ? mem_img[fetch_idx] : $urandom;
    if (!mem_img.exists(fetch_idx) || w[8*lane +: 8] != ins) begin
      w[8*lane +: 8] = ins;
      send_req(FUNC_WRITE, 16'(fetch_idx), w);
    end
    oper = cpu_oreg | ins[3:0];
    is_load = 1'b1;
    data_addr = '0;
    case (ins[7:4])
      OP_LDAM, OP_LDBM: data_addr = oper;
      OP_LDAI: data_addr = cpu_a + oper;
      OP_LDBI: data_addr = cpu_b + oper;
      default: is_load = 1'b0;
    endcase
    if (is_load && !mem_img.exists(word_idx(data_addr)))
      send_req(FUNC_WRITE, 16'(word_idx(data_addr)), $urandom);
    send_req(FUNC_EXEC, 16'($urandom), $urandom);
  endtask

  function automatic bit keeps_running(logic [7:0] ins);
    logic [31:0] sub;
    sub = cpu_oreg | ins[3:0];
    if (ins[7:4] == OP_UNUSED) return 1'b0;
    if (ins[7:4] == OP_OPR)
      return sub == OPR_BRB || sub == OPR_ADD || sub == OPR_SUB ||
             (sub == OPR_SVC && cpu_a != SVC_EXIT && cpu_a <= SVC_LAST_IO);
    return 1'b1;
  endfunction

  task automatic random_instruction();
    int unsigned fetch_idx;
    logic [7:0]  ins;
    fetch_idx = word_idx(cpu_pc >> 2);
    if (mem_img.exists(fetch_idx) && $urandom_range(1) == 1) begin
      ins = mem_img[fetch_idx][8*cpu_pc[1:0] +: 8];
      if (keeps_running(ins)) begin
        run_op(ins);
        return;
      end
    end
    do ins = 8'($urandom); while (!keeps_running(ins));
    run_op(ins);
  endtask

  task automatic random_mix(input int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    goal = useful_sent + n_items;
    while (useful_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        random_instruction();
      end else if (pick < 84) begin
        send_req(FUNC_WRITE, 16'($urandom), $urandom);
      end else if (pick < 88) begin
        send_req(FUNC_WRITE, 16'(word_idx(cpu_pc >> 2)), $urandom);
      end else if (pick < 96) begin
        send_req(FUNC_READ, written_addrs[$urandom_range(written_addrs.size() - 1)],
                 $urandom);
      end else begin
        send_req(FUNC_NONE, 16'($urandom), $urandom);
      end
    end
  endtask

  task automatic set_idling(input int unsigned idle, input int unsigned stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic test_host_access();
    send_req(FUNC_WRITE, 16'h0000, 32'h0000_0000);
    send_req(FUNC_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(FUNC_READ, 16'h0000, 32'hFFFF_FFFF);
    send_req(FUNC_READ, 16'hFFFF, 32'h0000_0000);
    send_req(FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_instructions();
    run_op({OP_LDAC, 4'd9});
    run_op({OP_LDBC, 4'd3});
    run_op({OP_OPR, OPR_ADD[3:0]});
    run_op({OP_OPR, OPR_SUB[3:0]});
    run_op({OP_STAM, 4'd10});
    run_op({OP_LDBM, 4'd10});
    run_op({OP_NFIX, 4'd0});
    run_op({OP_LDAM, 4'd5});
    run_op({OP_LDAP, 4'd2});
    run_op({OP_LDAI, 4'd0});
    run_op({OP_LDBI, 4'd10});
    run_op({OP_STAI, 4'd1});
    run_op({OP_LDAC, 4'd0});
    run_op({OP_BRZ, 4'd4});
    run_op({OP_BRN, 4'd3});
    run_op({OP_NFIX, 4'd0});
    run_op({OP_LDAC, 4'd0});
    run_op({OP_BRN, 4'd2});
    run_op({OP_BR, 4'd3});
    run_op({OP_PFIX, 4'd4});
    run_op({OP_LDBC, 4'd0});
    run_op({OP_OPR, OPR_BRB[3:0]});
  endtask

  task automatic test_io_syscalls();
    run_op({OP_LDAC, 4'd1});
    run_op({OP_OPR, OPR_SVC[3:0]});
    run_op({OP_LDAC, 4'd2});
    run_op({OP_OPR, OPR_SVC[3:0]});
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    random_mix(240);
    drain_results();
    set_idling(87, 0);
    random_mix(240);
    drain_results();
    set_idling(0, 87);
    random_mix(240);
    drain_results();
    set_idling(20, 20);
    random_mix(240);
    drain_results();
  endtask

  task automatic test_result_hold();
    set_idling(0, 0);
    hold_reqs <= hold_reqs + 1;
    random_mix(40);
    drain_results();
  endtask

  task automatic test_halt();
    set_idling(20, 20);
    run_op({OP_LDBC, 4'd0});
    case ($urandom_range(3))
      0: begin
        halt_cause = "exit request";
        run_op({OP_LDAC, 4'd0});
        run_op({OP_OPR, OPR_SVC[3:0]});
      end
      1: begin
        halt_cause = "unknown syscall";
        run_op({OP_LDAC, SVC_UNKNOWN});
        run_op({OP_OPR, OPR_SVC[3:0]});
      end
      2: begin
        halt_cause = "undefined opcode";
        run_op({OP_UNUSED, 4'($urandom)});
      end
      default: begin
        halt_cause = "undefined operate code";
        run_op({OP_OPR, OPR_UNDEF});
      end
    endcase
    send_req(FUNC_EXEC, 16'($urandom), $urandom);
    send_req(FUNC_EXEC, 16'($urandom), $urandom);
    send_req(FUNC_WRITE, 16'($urandom), $urandom);
    send_req(FUNC_READ, written_addrs[$urandom_range(written_addrs.size() - 1)], $urandom);
    send_req(FUNC_NONE, 16'($urandom), $urandom);
    drain_results();
  endtask

  initial begin
    cpu_pc = '0;
    cpu_a = '0;
    cpu_b = '0;
    cpu_oreg = '0;
    cpu_running = 1'b1;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_NONE;
    req_bus.word_addr = '0;
    req_bus.write_word = '0;
    rsp_bus.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_host_access();
    test_instructions();
    test_io_syscalls();
    drain_results();
    test_random_traffic();
    test_result_hold();
    test_halt();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results over four idle and stall mixes,",
             useful_sent, results_checked);
    $display("a %0d-cycle result hold, drain pauses and a final halt by %s.",
             HOLD_CYCLES, halt_cause);
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("prefix_accumulator_cpu_core_tb: done, clean");
    end else begin
      $display("prefix_accumulator_cpu_core_tb: done, errors");
    end
    $finish;
  end

endmodule
